FILE: hw/rtl/hufd_pkg.sv
// ============================================================================
// hufd_pkg
// shared types and constants of the huffman tree decoder
// ============================================================================
`default_nettype none

package hufd_pkg;

    localparam int OP_W    = 2;
    localparam int SYM_W   = 8;
    localparam int CODE_W  = 32;
    localparam int CODE_IW = 5;
    localparam int LEN_W   = 6;
    localparam int KIND_W  = 2;

    // symbol of the root and of every new interior node
    localparam logic [SYM_W-1:0] EMPTY_SYMBOL = 8'h24;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_DECODE = 2'd2,
        OP_PASS   = 2'd3
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_SYMBOL    = 2'd0,
        KIND_SEPARATOR = 2'd1,
        KIND_FULL      = 2'd2
    } t_kind;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DEC      = 6'b000010,
        S_DEC_LEAF = 6'b000100,
        S_INS_STEP = 6'b001000,
        S_INS_LINK = 6'b010000,
        S_SEP      = 6'b100000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic  load;
        logic  clear;
        logic  ins_start;
        logic  dec_start;
        logic  descend;
        logic  alloc;
        logic  link;
        logic  next;
        logic  dec_move;
        logic  walk_set;
        logic  emit;
        t_kind kind;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_op  in_op;
        logic in_len_zero;
        logic need_alloc;
        logic full;
        logic pos_zero;
        logic moved;
        logic leaf;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

FILE: hw/rtl/hufd_in_if.sv
// ============================================================================
// hufd_in_if
// input word channel: opcode, symbol, code and decode bit
// ============================================================================
`default_nettype none

interface hufd_in_if;
    logic                         valid;
    logic                         ready;
    logic [hufd_pkg::OP_W-1:0]    opcode;
    logic [hufd_pkg::SYM_W-1:0]   symbol;
    logic [hufd_pkg::CODE_W-1:0]  code_bits;
    logic [hufd_pkg::LEN_W-1:0]   code_length;
    logic                         bit_req;

    modport source (
        output valid, opcode, symbol, code_bits, code_length, bit_req,
        input  ready
    );
    modport sink (
        input  valid, opcode, symbol, code_bits, code_length, bit_req,
        output ready
    );
endinterface

`default_nettype wire

FILE: hw/rtl/hufd_out_if.sv
// ============================================================================
// hufd_out_if
// result word channel: symbol and kind
// ============================================================================
`default_nettype none

interface hufd_out_if;
    logic                         valid;
    logic                         ready;
    logic [hufd_pkg::SYM_W-1:0]   out_symbol;
    logic [hufd_pkg::KIND_W-1:0]  kind;

    modport source (
        output valid, out_symbol, kind,
        input  ready
    );
    modport sink (
        input  valid, out_symbol, kind,
        output ready
    );
endinterface

`default_nettype wire

FILE: hw/rtl/hufd_ram.sv
// ============================================================================
// hufd_ram
// simple dual port ram, one write port, one read port with registered data
// ============================================================================
`default_nettype none

module hufd_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/hufd_ctrl.sv
// ============================================================================
// hufd_ctrl
// sequencer for clear, insert, decode and pass-through words
// ============================================================================
`default_nettype none

module hufd_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire hufd_pkg::t_sts i_sts,
    output hufd_pkg::t_cmd      o_cmd
);

    hufd_pkg::t_state r_state;
    hufd_pkg::t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.kind = hufd_pkg::KIND_SYMBOL;
        o_in_ready = 1'b0;

        unique case (r_state)
            hufd_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (i_sts.in_op)
                        hufd_pkg::OP_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        hufd_pkg::OP_INSERT: begin
                            if (!i_sts.in_len_zero) begin
                                o_cmd.ins_start = 1'b1;
                                n_state         = hufd_pkg::S_INS_STEP;
                            end
                        end
                        hufd_pkg::OP_DECODE: begin
                            o_cmd.dec_start = 1'b1;
                            n_state         = hufd_pkg::S_DEC;
                        end
                        hufd_pkg::OP_PASS: begin
                            n_state = hufd_pkg::S_SEP;
                        end
                        default: begin
                            n_state = hufd_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            hufd_pkg::S_INS_STEP: begin
                if (!i_sts.need_alloc) begin
                    o_cmd.descend = 1'b1;
                end else if (i_sts.full) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.kind = hufd_pkg::KIND_FULL;
                        n_state    = hufd_pkg::S_IDLE;
                    end
                end else begin
                    o_cmd.alloc = 1'b1;
                    n_state     = hufd_pkg::S_INS_LINK;
                end
            end

            hufd_pkg::S_INS_LINK: begin
                o_cmd.link = 1'b1;
                if (i_sts.pos_zero) begin
                    n_state = hufd_pkg::S_IDLE;
                end else begin
                    o_cmd.next = 1'b1;
                    n_state    = hufd_pkg::S_INS_STEP;
                end
            end

            hufd_pkg::S_DEC: begin
                if (i_sts.moved) begin
                    o_cmd.dec_move = 1'b1;
                    n_state        = hufd_pkg::S_DEC_LEAF;
                end else if (!i_sts.leaf) begin
                    o_cmd.walk_set = 1'b1;
                    n_state        = hufd_pkg::S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.walk_set = 1'b1;
                    o_cmd.emit     = 1'b1;
                    n_state        = hufd_pkg::S_IDLE;
                end
            end

            hufd_pkg::S_DEC_LEAF: begin
                if (!i_sts.leaf) begin
                    o_cmd.walk_set = 1'b1;
                    n_state        = hufd_pkg::S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.walk_set = 1'b1;
                    o_cmd.emit     = 1'b1;
                    n_state        = hufd_pkg::S_IDLE;
                end
            end

            hufd_pkg::S_SEP: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = hufd_pkg::KIND_SEPARATOR;
                    n_state    = hufd_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = hufd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hufd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/hufd_datapath.sv
// ============================================================================
// hufd_datapath
// node table, root links, walk pointer, insert cursor and result register
// ============================================================================
`default_nettype none

module hufd_datapath #(
    parameter int NODE_COUNT   = 512,
    parameter int MAX_CODE_LEN = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire hufd_pkg::t_cmd                i_cmd,
    output hufd_pkg::t_sts                     o_sts,
    input  wire logic [hufd_pkg::OP_W-1:0]     i_in_opcode,
    input  wire logic [hufd_pkg::SYM_W-1:0]    i_in_symbol,
    input  wire logic [hufd_pkg::CODE_W-1:0]   i_in_code_bits,
    input  wire logic [hufd_pkg::LEN_W-1:0]    i_in_code_length,
    input  wire logic                          i_in_bit_req,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic      [hufd_pkg::SYM_W-1:0]    o_out_symbol,
    output logic      [hufd_pkg::KIND_W-1:0]   o_out_kind
);

    localparam int IW = $clog2(NODE_COUNT);
    localparam int UW = $clog2(NODE_COUNT + 1);
    localparam int EW = 2 * IW + hufd_pkg::SYM_W;

    // control state
    logic [IW-1:0] r_root_left;
    logic [IW-1:0] r_root_right;
    logic [UW-1:0] r_used;
    logic [IW-1:0] r_walk;
    logic          r_out_valid;

    // payload
    logic [IW-1:0]                 r_p;
    logic [IW-1:0]                 r_new;
    logic                          r_use_q;
    logic [EW-1:0]                 r_cache;
    logic [hufd_pkg::LEN_W-1:0]    r_pos;
    logic [hufd_pkg::SYM_W-1:0]    r_sym;
    logic [hufd_pkg::CODE_W-1:0]   r_code;
    logic                          r_bit;
    logic [hufd_pkg::SYM_W-1:0]    r_out_sym;
    logic [hufd_pkg::KIND_W-1:0]   r_out_kind;

    logic [EW-1:0]                 ram_rdata;
    logic                          ram_we;
    logic [IW-1:0]                 ram_waddr;
    logic [EW-1:0]                 ram_wdata;
    logic                          ram_re;
    logic [IW-1:0]                 ram_raddr;

    logic [EW-1:0]                 nd_entry;
    logic [IW-1:0]                 nd_left;
    logic [IW-1:0]                 nd_right;
    logic [hufd_pkg::SYM_W-1:0]    nd_sym;
    logic                          ins_bit;
    logic [IW-1:0]                 ins_child;
    logic [IW-1:0]                 dec_child;
    logic                          full;
    logic                          leaf;
    logic                          out_free;
    logic [hufd_pkg::LEN_W-1:0]    in_len_eff;
    logic [IW-1:0]                 walk_eff;

    // current node: root from flip-flops, others from ram or the walk cache
    always_comb begin
        nd_entry = r_use_q ? ram_rdata : r_cache;
        if (r_p == '0) begin
            nd_left  = r_root_left;
            nd_right = r_root_right;
            nd_sym   = hufd_pkg::EMPTY_SYMBOL;
        end else begin
            nd_left  = nd_entry[EW-1 -: IW];
            nd_right = nd_entry[hufd_pkg::SYM_W+IW-1 -: IW];
            nd_sym   = nd_entry[hufd_pkg::SYM_W-1:0];
        end
    end

    // code bits above the field width read as zero
    assign ins_bit   = (r_pos < hufd_pkg::LEN_W'(hufd_pkg::CODE_W))
                     ? r_code[r_pos[hufd_pkg::CODE_IW-1:0]] : 1'b0;
    assign ins_child = ins_bit ? nd_right : nd_left;
    assign dec_child = r_bit ? nd_right : nd_left;
    assign full      = (r_used == UW'(NODE_COUNT));
    assign leaf      = (nd_left == '0) && (nd_right == '0);
    assign out_free  = !r_out_valid || i_out_ready;

    assign in_len_eff = (32'(i_in_code_length) > MAX_CODE_LEN)
                      ? hufd_pkg::LEN_W'(MAX_CODE_LEN) : i_in_code_length;
    assign walk_eff   = (UW'(r_walk) >= r_used) ? '0 : r_walk;

    always_comb begin
        o_sts.in_op       = hufd_pkg::t_op'(i_in_opcode);
        o_sts.in_len_zero = (i_in_code_length == '0);
        o_sts.need_alloc  = (r_pos == '0) || (ins_child == '0);
        o_sts.full        = full;
        o_sts.pos_zero    = (r_pos == '0);
        o_sts.moved       = (dec_child != '0);
        o_sts.leaf        = leaf;
        o_sts.out_free    = out_free;
    end

    // new node on alloc, parent link rewrite on link
    always_comb begin
        ram_we    = i_cmd.alloc || (i_cmd.link && (r_p != '0));
        ram_waddr = i_cmd.alloc ? r_used[IW-1:0] : r_p;
        if (i_cmd.alloc) begin
            ram_wdata = {{(2 * IW){1'b0}},
                         (r_pos == '0) ? r_sym : hufd_pkg::EMPTY_SYMBOL};
        end else if (ins_bit) begin
            ram_wdata = {nd_left, r_new, nd_sym};
        end else begin
            ram_wdata = {r_new, nd_right, nd_sym};
        end
        ram_re = i_cmd.descend || i_cmd.next || i_cmd.dec_move;
        if (i_cmd.next) begin
            ram_raddr = r_new;
        end else if (i_cmd.descend) begin
            ram_raddr = ins_child;
        end else begin
            ram_raddr = dec_child;
        end
    end

    hufd_ram #(
        .WIDTH (EW),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_left  <= '0;
            r_root_right <= '0;
            r_used       <= UW'(1);
            r_walk       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_root_left  <= '0;
                r_root_right <= '0;
                r_used       <= UW'(1);
                r_walk       <= '0;
            end
            if (i_cmd.ins_start) begin
                r_walk <= '0;
            end
            if (i_cmd.alloc) begin
                r_used <= r_used + UW'(1);
            end
            if (i_cmd.link && (r_p == '0)) begin
                if (ins_bit) begin
                    r_root_right <= r_new;
                end else begin
                    r_root_left <= r_new;
                end
            end
            if (i_cmd.walk_set) begin
                r_walk <= leaf ? '0 : r_p;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sym  <= i_in_symbol;
            r_code <= i_in_code_bits;
            r_bit  <= i_in_bit_req;
        end
        if (i_cmd.ins_start) begin
            r_p     <= '0;
            r_pos   <= in_len_eff - hufd_pkg::LEN_W'(1);
            r_use_q <= 1'b0;
        end
        if (i_cmd.dec_start) begin
            r_p     <= walk_eff;
            r_use_q <= 1'b0;
        end
        if (i_cmd.descend) begin
            r_p     <= ins_child;
            r_pos   <= r_pos - hufd_pkg::LEN_W'(1);
            r_use_q <= 1'b1;
        end
        if (i_cmd.alloc) begin
            r_new <= r_used[IW-1:0];
        end
        if (i_cmd.next) begin
            r_p     <= r_new;
            r_pos   <= r_pos - hufd_pkg::LEN_W'(1);
            r_use_q <= 1'b1;
        end
        if (i_cmd.dec_move) begin
            r_p     <= dec_child;
            r_use_q <= 1'b1;
        end
        if (i_cmd.walk_set && !leaf) begin
            r_cache <= {nd_left, nd_right, nd_sym};
        end
        if (i_cmd.emit) begin
            r_out_sym  <= (i_cmd.kind == hufd_pkg::KIND_SYMBOL) ? nd_sym : r_sym;
            r_out_kind <= i_cmd.kind;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_symbol = r_out_sym;
    assign o_out_kind   = r_out_kind;

    // allocation grows the table by exactly one entry
    a_alloc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.alloc |=> r_used == $past(r_used) + UW'(1))
        else $error("node count did not step by one");

    // allocation never runs past the table
    a_alloc_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.alloc |-> !full)
        else $error("allocation with a full table");

    // the walk always sits on an allocated node
    a_walk_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        UW'(r_walk) < r_used)
        else $error("walk points past allocated nodes");

    // a result is loaded only into a free or draining slot
    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("result overwrote a pending word");

endmodule

`default_nettype wire

FILE: hw/rtl/huffman_tree_decoder.sv
// ============================================================================
// huffman_tree_decoder
// binary decoding tree kept in a node ram: clear, insert code, decode bit and
// separator pass-through, with a registered result slot
// ============================================================================
//
//  channel   dir   handshake       payload
//  -------   ---   -------------   --------------------------------------------
//  i_in      in    valid / ready   opcode, symbol, code_bits, code_length,
//                                  bit_req
//  o_out     out   valid / ready   out_symbol, kind
//
//  steps: clear and zero-length insert finish on acceptance; a decode bit that
//  follows a child does one ram read; an insert steps down the code, and
//  each new node costs a node write and a parent link write
//  reset: synchronous; root links in flip-flops give a lone root at once
//  stalls: a word is accepted only between items; a result waits in the
//  output register, and the next word is taken while it waits
//
`default_nettype none

module huffman_tree_decoder #(
    parameter int NODE_COUNT   = 512,
    parameter int MAX_CODE_LEN = 32
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    hufd_in_if.sink   i_in,
    hufd_out_if.source o_out
);

    // command and status between the sequencer and the datapath
    hufd_pkg::t_cmd cmd;
    hufd_pkg::t_sts sts;
    logic           in_ready;

    // sequencer: walks one word at a time through its steps
    hufd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    assign i_in.ready = in_ready;

    // datapath: node ram, root links, walk pointer, insert cursor, result slot
    hufd_datapath #(
        .NODE_COUNT   (NODE_COUNT),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_in_opcode      (i_in.opcode),
        .i_in_symbol      (i_in.symbol),
        .i_in_code_bits   (i_in.code_bits),
        .i_in_code_length (i_in.code_length),
        .i_in_bit_req     (i_in.bit_req),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_out_symbol     (o_out.out_symbol),
        .o_out_kind       (o_out.kind)
    );

endmodule

`default_nettype wire

FILE: dv/tb.sv
// ============================================================================
// tb
// self-checking bench for huffman_tree_decoder: a behavioral copy of the
// node table predicts every result word, random gaps stall both channels
// ============================================================================
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODE_COUNT   = 512;
    localparam int MAX_CODE_LEN = 32;
    localparam int IDX_W        = $clog2(NODE_COUNT);
    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 10;
    // the drain outlasts the longest insert that gives no result word
    localparam int DRAIN_CYCLES = 4 * MAX_CODE_LEN + 100;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_WORDS = 660;

    localparam logic [hufd_pkg::SYM_W-1:0] SEP_SPACE   = 8'h20;
    localparam logic [hufd_pkg::SYM_W-1:0] SEP_NEWLINE = 8'h0a;
    localparam logic [hufd_pkg::SYM_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [hufd_pkg::SYM_W-1:0] CHAR_ONE    = 8'h31;

    // one expected result word
    typedef struct {
        logic [hufd_pkg::SYM_W-1:0] sym;
        hufd_pkg::t_kind            kind;
    } t_tree_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hufd_in_if  in_ch ();
    hufd_out_if out_ch ();

    huffman_tree_decoder #(
        .NODE_COUNT   (NODE_COUNT),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // predicted tree: child links (0 = no child), symbols, allocation and walk
    // ------------------------------------------------------------------------
    logic [IDX_W-1:0]           tree_left  [NODE_COUNT];
    logic [IDX_W-1:0]           tree_right [NODE_COUNT];
    logic [hufd_pkg::SYM_W-1:0] tree_sym   [NODE_COUNT];
    int                         tree_nodes;
    logic [IDX_W-1:0]           walk_node;

    t_tree_result pending_results [$];

    int  err_count   = 0;
    int  cycle_count = 0;
    int  words_sent  = 0;
    // set for stretches where neither side idles
    bit  no_gaps     = 1'b0;
    int  stall_left  = 0;

    // append one expected word at the tail of the queue
    function automatic void expect_word(input logic [hufd_pkg::SYM_W-1:0] s,
                                        input hufd_pkg::t_kind k);
        t_tree_result r;
        r.sym  = s;
        r.kind = k;
        pending_results.insert(pending_results.size(), r);
    endfunction

    // clear shrinks the tree to a lone root, old entries stay but are unreachable
    function automatic void tree_make_root();
        tree_left[0]  = '0;
        tree_right[0] = '0;
        tree_sym[0]   = hufd_pkg::EMPTY_SYMBOL;
        tree_nodes    = 1;
        walk_node     = '0;
    endfunction

    // returns the new index, 0 when the table is full
    function automatic logic [IDX_W-1:0] tree_alloc(input logic [hufd_pkg::SYM_W-1:0] s);
        logic [IDX_W-1:0] idx;
        if (tree_nodes >= NODE_COUNT)
            return '0;
        idx = IDX_W'(tree_nodes);
        tree_nodes++;
        tree_left[idx]  = '0;
        tree_right[idx] = '0;
        tree_sym[idx]   = s;
        return idx;
    endfunction

    // walk the code msb first, make missing interior nodes, hang a fresh leaf
    // on the last step; nodes made before a full table stay in the tree
    function automatic bit tree_insert(input logic [hufd_pkg::SYM_W-1:0] s,
                                       input logic [hufd_pkg::CODE_W-1:0] code,
                                       input int len);
        logic [IDX_W-1:0] p;
        logic [IDX_W-1:0] child;
        int               pos;
        p = '0;
        for (pos = len - 1; pos > 0; pos--) begin
            child = code[pos] ? tree_right[p] : tree_left[p];
            if (child == 0) begin
                child = tree_alloc(hufd_pkg::EMPTY_SYMBOL);
                if (child == 0)
                    return 1'b0;
                if (code[pos])
                    tree_right[p] = child;
                else
                    tree_left[p] = child;
            end
            p = child;
        end
        child = tree_alloc(s);
        if (child == 0)
            return 1'b0;
        // the final link is always overwritten, an old subtree there is dropped
        if (code[0])
            tree_right[p] = child;
        else
            tree_left[p] = child;
        return 1'b1;
    endfunction

    // update the predicted tree for one accepted word and queue its result
    function automatic void predict_word(input hufd_pkg::t_op op,
                                         input logic [hufd_pkg::SYM_W-1:0] sym,
                                         input logic [hufd_pkg::CODE_W-1:0] code,
                                         input logic [hufd_pkg::LEN_W-1:0] len,
                                         input logic bit_req);
        logic [IDX_W-1:0] p;
        int               eff_len;
        case (op)
            hufd_pkg::OP_CLEAR: begin
                tree_make_root();
            end
            hufd_pkg::OP_INSERT: begin
                // zero length leaves everything alone, long codes are clipped
                if (len != 0) begin
                    eff_len = (len > MAX_CODE_LEN) ? MAX_CODE_LEN : int'(len);
                    walk_node = '0;
                    if (!tree_insert(sym, code, eff_len))
                        expect_word(sym, hufd_pkg::KIND_FULL);
                end
            end
            hufd_pkg::OP_DECODE: begin
                p = walk_node;
                if (p >= tree_nodes)
                    p = '0;
                // a missing child keeps the walk where it is
                if (!bit_req && tree_left[p] != 0)
                    p = tree_left[p];
                else if (bit_req && tree_right[p] != 0)
                    p = tree_right[p];
                // leaf test applies even when the walk did not move
                if (tree_left[p] == 0 && tree_right[p] == 0) begin
                    expect_word(tree_sym[p], hufd_pkg::KIND_SYMBOL);
                    walk_node = '0;
                end else begin
                    walk_node = p;
                end
            end
            default: begin
                expect_word(sym, hufd_pkg::KIND_SEPARATOR);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // random gap lengths: mostly none or short, a few long
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // insert lengths: mostly short, some up to the max, a few clipped or zero
    function automatic logic [hufd_pkg::LEN_W-1:0] pick_code_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return hufd_pkg::LEN_W'($urandom_range(1, 6));
        if (r < 90)
            return hufd_pkg::LEN_W'($urandom_range(7, MAX_CODE_LEN));
        if (r < 96)
            return hufd_pkg::LEN_W'($urandom_range(MAX_CODE_LEN + 1,
                                                   (1 << hufd_pkg::LEN_W) - 1));
        return '0;
    endfunction

    // ------------------------------------------------------------------------
    // input driver: drive at the falling edge, accept at the rising edge
    // ------------------------------------------------------------------------
    task automatic send_word(input hufd_pkg::t_op op,
                             input logic [hufd_pkg::SYM_W-1:0] sym,
                             input logic [hufd_pkg::CODE_W-1:0] code,
                             input logic [hufd_pkg::LEN_W-1:0] len,
                             input logic bit_req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= op;
        in_ch.symbol      <= sym;
        in_ch.code_bits   <= code;
        in_ch.code_length <= len;
        in_ch.bit_req     <= bit_req;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        predict_word(op, sym, code, len, bit_req);
        words_sent++;
    endtask

    // ------------------------------------------------------------------------
    // result sink: random back-pressure, ready changes at the falling edge
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left <= pick_gap();
        end
    end

    // every accepted result word is checked against the oldest prediction
    always @(posedge i_clk) begin : check_result
        t_tree_result want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word: symbol %h kind %0d",
                         $realtime, out_ch.out_symbol, out_ch.kind);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_ch.out_symbol !== want.sym) begin
                    $display("%0t: out_symbol mismatch: expected %h, actual %h",
                             $realtime, want.sym, out_ch.out_symbol);
                    err_count++;
                end
                if (out_ch.kind !== want.kind) begin
                    $display("%0t: kind mismatch: expected %0d, actual %0d",
                             $realtime, want.kind, out_ch.kind);
                    err_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // lone root, separators, zero length, replaced leaf, missing child, clipping
    task automatic test_directed();
        send_word(hufd_pkg::OP_DECODE, 8'h00, 32'h0, 6'd0, 1'b0);  // lone root gives '$'
        send_word(hufd_pkg::OP_DECODE, 8'hff, 32'hffffffff, 6'd63, 1'b1);
        send_word(hufd_pkg::OP_PASS, 8'h00, 32'h0, 6'd0, 1'b0);
        send_word(hufd_pkg::OP_PASS, 8'hff, 32'hffffffff, 6'd63, 1'b1);
        send_word(hufd_pkg::OP_PASS, SEP_SPACE, 32'h0, 6'd1, 1'b0);
        send_word(hufd_pkg::OP_PASS, SEP_NEWLINE, 32'h0, 6'd1, 1'b0);
        // zero length, no effect
        send_word(hufd_pkg::OP_INSERT, 8'h5a, 32'hffffffff, 6'd0, 1'b1);
        send_word(hufd_pkg::OP_DECODE, 8'h00, 32'h0, 6'd0, 1'b0);
        send_word(hufd_pkg::OP_INSERT, 8'h41, 32'h0, 6'd1, 1'b0);  // '0' -> A
        send_word(hufd_pkg::OP_INSERT, 8'h42, 32'h1, 6'd1, 1'b0);  // '1' -> B
        send_word(hufd_pkg::OP_DECODE, 8'h00, 32'h0, 6'd0, 1'b0);
        send_word(hufd_pkg::OP_DECODE, 8'h00, 32'h0, 6'd0, 1'b1);
        // '10' -> C under old leaf B
        send_word(hufd_pkg::OP_INSERT, 8'h43, 32'h2, 6'd2, 1'b0);
        send_word(hufd_pkg::OP_DECODE, 8'h00, 32'h0, 6'd0, 1'b1);  // into B, now interior
        send_word(hufd_pkg::OP_DECODE, 8'h00, 32'h0, 6'd0, 1'b1);  // no right child, stays
        send_word(hufd_pkg::OP_DECODE, 8'h00, 32'h0, 6'd0, 1'b0);  // C
        // clipped to max length
        send_word(hufd_pkg::OP_INSERT, 8'hff, 32'hffffffff, 6'd63, 1'b0);
        send_word(hufd_pkg::OP_INSERT, 8'h00, 32'h0, 6'(MAX_CODE_LEN), 1'b1);
        send_word(hufd_pkg::OP_DECODE, 8'h00, 32'h0, 6'd0, 1'b1);
        send_word(hufd_pkg::OP_DECODE, 8'h00, 32'h0, 6'd0, 1'b0);
        send_word(hufd_pkg::OP_PASS, CHAR_ZERO, 32'h0, 6'd0, 1'b0);
        send_word(hufd_pkg::OP_PASS, CHAR_ONE, 32'h0, 6'd0, 1'b0);
        send_word(hufd_pkg::OP_CLEAR, 8'h00, 32'h0, 6'd0, 1'b0);
        send_word(hufd_pkg::OP_DECODE, 8'h00, 32'h0, 6'd0, 1'b1);
    endtask

    // long random codes until the node table runs out, then decode through it
    task automatic test_table_full();
        send_word(hufd_pkg::OP_CLEAR, 8'($urandom), $urandom, 6'($urandom),
                  1'($urandom));
        while (tree_nodes < NODE_COUNT)
            send_word(hufd_pkg::OP_INSERT, 8'($urandom), $urandom, 6'(MAX_CODE_LEN),
                      1'($urandom));
        repeat (4)
            send_word(hufd_pkg::OP_INSERT, 8'($urandom), $urandom, pick_code_length(),
                      1'($urandom));
        repeat (80)
            send_word(hufd_pkg::OP_DECODE, 8'($urandom), $urandom, 6'($urandom),
                      1'($urandom));
        send_word(hufd_pkg::OP_CLEAR, 8'($urandom), $urandom, 6'($urandom),
                  1'($urandom));
        send_word(hufd_pkg::OP_DECODE, 8'($urandom), $urandom, 6'($urandom),
                  1'($urandom));
    endtask

    // build small trees and decode bit streams through them, with noise bursts
    task automatic test_random();
        int target;
        int n;
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target) begin
            no_gaps = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 9) == 0) begin
                // noise: any opcode, any field value
                n = $urandom_range(5, 15);
                repeat (n)
                    send_word(hufd_pkg::t_op'(2'($urandom)), 8'($urandom), $urandom,
                              6'($urandom), 1'($urandom));
            end else begin
                send_word(hufd_pkg::OP_CLEAR, 8'($urandom), $urandom, 6'($urandom),
                          1'($urandom));
                n = $urandom_range(2, 10);
                repeat (n)
                    send_word(hufd_pkg::OP_INSERT, 8'($urandom), $urandom,
                              pick_code_length(), 1'($urandom));
                n = $urandom_range(10, 50);
                repeat (n) begin
                    if ($urandom_range(0, 9) == 0)
                        send_word(hufd_pkg::OP_PASS, 8'($urandom), $urandom,
                                  6'($urandom), 1'($urandom));
                    else
                        send_word(hufd_pkg::OP_DECODE, 8'($urandom), $urandom,
                                  6'($urandom), 1'($urandom));
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        for (int k = 0; k < NODE_COUNT; k++) begin
            tree_left[k]  = '0;
            tree_right[k] = '0;
            tree_sym[k]   = '0;
        end
        tree_make_root();

        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.opcode      = hufd_pkg::OP_CLEAR;
        in_ch.symbol      = '0;
        in_ch.code_bits   = '0;
        in_ch.code_length = '0;
        in_ch.bit_req     = 1'b0;
        out_ch.ready      = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_table_full();
        test_random();

        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
